>>> hdl/east_pkg.sv
// ----------------------------------------------------------------------------
// Envelope auto start trigger package
// Shared widths, register indexes and reset values of the trigger block.
// ----------------------------------------------------------------------------
package east_pkg;

  // Default widths for the top-level parameters.
  localparam int LEVEL_BITS_DEF = 23;
  localparam int COUNT_BITS_DEF = 20;

  // Fixed field widths.
  localparam int COEF_BITS    = 16;
  localparam int SENS_BITS    = 17;
  localparam int CFG_IDX_BITS = 3;

  // Unity in Q1.16 and 0.6 in Q0.16, rounded to nearest.
  localparam logic [SENS_BITS-1:0] ONE_Q16       = 17'h10000;
  localparam logic [COEF_BITS-1:0] OFF_RATIO_Q16 = 16'd39322;

  // Register reset values.
  localparam logic [COEF_BITS-1:0] RST_ATTACK    = 16'd655;
  localparam logic [COEF_BITS-1:0] RST_RELEASE   = 16'd66;
  localparam logic [31:0]          RST_THR_HIGH  = 32'd838861;
  localparam logic [31:0]          RST_THR_FLOOR = 32'd83886;
  localparam logic [SENS_BITS-1:0] RST_SENS      = 17'h10000;
  localparam logic [31:0]          RST_HOLD      = 32'd480;
  localparam logic [31:0]          RST_REARM     = 32'd24000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ATTACK      = 3'd0,
    CFG_RELEASE     = 3'd1,
    CFG_THR_HIGH    = 3'd2,
    CFG_THR_FLOOR   = 3'd3,
    CFG_SENSITIVITY = 3'd4,
    CFG_START_HOLD  = 3'd5,
    CFG_REARM       = 3'd6,
    CFG_ENABLE      = 3'd7
  } cfg_idx_e;

  // Larger of two widths.
  function automatic int east_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> hdl/east_if.sv
// ----------------------------------------------------------------------------
// Envelope auto start trigger stream interfaces
// Valid/ready channels for input samples and for trigger results.
// ----------------------------------------------------------------------------
interface east_in_if
  import east_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic                  recording_active;
  logic                  clear_counters;

  modport source (output valid, level, recording_active, clear_counters, input ready);
  modport sink   (input valid, level, recording_active, clear_counters, output ready);
endinterface

interface east_out_if
  import east_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  start_request;
  logic                  armed;
  logic [LEVEL_BITS-1:0] envelope;

  modport source (output valid, start_request, armed, envelope, input ready);
  modport sink   (input valid, start_request, armed, envelope, output ready);
endinterface

>>> hdl/east_cfg_regs.sv
// ----------------------------------------------------------------------------
// Envelope auto start trigger configuration registers
// Holds the registers and derives the on and off thresholds in two stages.
// ----------------------------------------------------------------------------
module east_cfg_regs
  import east_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]                          cfg_idx_i,
  input  logic [east_max(east_max(LEVEL_BITS, COUNT_BITS), SENS_BITS)-1:0] cfg_data_i,
  output logic [COEF_BITS-1:0]                             attack_o,
  output logic [COEF_BITS-1:0]                             release_o,
  output logic [LEVEL_BITS-1:0]                            thr_on_o,
  output logic [LEVEL_BITS-1:0]                            thr_off_o,
  output logic [COUNT_BITS-1:0]                            hold_o,
  output logic [COUNT_BITS-1:0]                            rearm_o,
  output logic                                             trig_en_o,
  output logic                                             thr_ready_o
);

  logic [COEF_BITS-1:0]  attack_q, release_q;
  logic [LEVEL_BITS-1:0] thr_high_q, thr_floor_q;
  logic [SENS_BITS-1:0]  sens_q;
  logic [COUNT_BITS-1:0] hold_q, rearm_q;
  logic                  enable_q;
  logic [LEVEL_BITS-1:0] thr_on_q, thr_on_d, thr_off_q;
  logic [1:0]            settle_q;

  logic [SENS_BITS-1:0]          sens_sat;
  logic signed [LEVEL_BITS:0]    thr_diff;
  logic signed [LEVEL_BITS+18:0] thr_prod;
  logic signed [LEVEL_BITS+2:0]  thr_sum;
  logic [LEVEL_BITS+15:0]        off_prod;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q    <= RST_ATTACK;
      release_q   <= RST_RELEASE;
      thr_high_q  <= RST_THR_HIGH[LEVEL_BITS-1:0];
      thr_floor_q <= RST_THR_FLOOR[LEVEL_BITS-1:0];
      sens_q      <= RST_SENS;
      hold_q      <= RST_HOLD[COUNT_BITS-1:0];
      rearm_q     <= RST_REARM[COUNT_BITS-1:0];
      enable_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ATTACK:      attack_q    <= cfg_data_i[COEF_BITS-1:0];
        CFG_RELEASE:     release_q   <= cfg_data_i[COEF_BITS-1:0];
        CFG_THR_HIGH:    thr_high_q  <= cfg_data_i[LEVEL_BITS-1:0];
        CFG_THR_FLOOR:   thr_floor_q <= cfg_data_i[LEVEL_BITS-1:0];
        CFG_SENSITIVITY: sens_q      <= cfg_data_i[SENS_BITS-1:0];
        CFG_START_HOLD:  hold_q      <= cfg_data_i[COUNT_BITS-1:0];
        CFG_REARM:       rearm_q     <= cfg_data_i[COUNT_BITS-1:0];
        CFG_ENABLE:      enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // On threshold: interpolate from the high threshold toward the floor.
  always_comb begin
    sens_sat = (sens_q > ONE_Q16) ? ONE_Q16 : sens_q;
    thr_diff = $signed({1'b0, thr_floor_q}) - $signed({1'b0, thr_high_q});
    thr_prod = thr_diff * $signed({1'b0, sens_sat});
    thr_sum  = $signed({3'b000, thr_high_q}) + $signed(thr_prod[LEVEL_BITS+18:16]);
    thr_on_d = thr_sum[LEVEL_BITS-1:0];
    off_prod = thr_on_q * OFF_RATIO_Q16;
  end

  // Threshold pipeline; payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    thr_on_q  <= thr_on_d;
    thr_off_q <= off_prod[LEVEL_BITS+15:16];
  end

  // Settle counter: holds samples off until both thresholds are current.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd2;
    end else if (cfg_we_i) begin
      settle_q <= 2'd2;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  assign attack_o    = attack_q;
  assign release_o   = release_q;
  assign thr_on_o    = thr_on_q;
  assign thr_off_o   = thr_off_q;
  assign hold_o      = hold_q;
  assign rearm_o     = rearm_q;
  assign trig_en_o   = enable_q && (sens_q != '0);
  assign thr_ready_o = (settle_q == 2'd0);

endmodule

>>> hdl/east_core.sv
// ----------------------------------------------------------------------------
// Envelope auto start trigger datapath
// Input register, envelope update, hysteresis gate and result register.
// ----------------------------------------------------------------------------
module east_core
  import east_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  east_in_if.sink               in_if,
  east_out_if.source            out_if,
  input  logic [COEF_BITS-1:0]  attack_i,
  input  logic [COEF_BITS-1:0]  release_i,
  input  logic [LEVEL_BITS-1:0] thr_on_i,
  input  logic [LEVEL_BITS-1:0] thr_off_i,
  input  logic [COUNT_BITS-1:0] hold_i,
  input  logic [COUNT_BITS-1:0] rearm_i,
  input  logic                  trig_en_i,
  input  logic                  thr_ready_i
);

  // Input register.
  logic                  s1_valid_q;
  logic [LEVEL_BITS-1:0] s1_level_q;
  logic                  s1_rec_q, s1_clear_q;

  // Block state.
  logic [LEVEL_BITS-1:0] env_q, env_d;
  logic [COUNT_BITS-1:0] loud_q, loud_d, quiet_q, quiet_d;
  logic                  armed_q, armed_d, start_d;

  // Result register.
  logic                  out_valid_q, out_start_q, out_armed_q;
  logic [LEVEL_BITS-1:0] out_env_q;

  logic                          advance;
  logic [COEF_BITS-1:0]          coef;
  logic signed [LEVEL_BITS:0]    env_diff;
  logic signed [LEVEL_BITS+17:0] env_prod;
  logic signed [LEVEL_BITS+1:0]  env_sum;
  logic [COUNT_BITS-1:0]         loud_c, quiet_c, loud_inc, quiet_inc;

  // The item in the input register moves on when the result register is free.
  assign advance     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = (!s1_valid_q || advance) && thr_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_level_q <= in_if.level;
      s1_rec_q   <= in_if.recording_active;
      s1_clear_q <= in_if.clear_counters;
    end
  end

  // Envelope: env + floor(coef * (level - env) / 65536).
  always_comb begin
    coef     = (s1_level_q > env_q) ? attack_i : release_i;
    env_diff = $signed({1'b0, s1_level_q}) - $signed({1'b0, env_q});
    env_prod = env_diff * $signed({1'b0, coef});
    env_sum  = $signed({2'b00, env_q}) + $signed(env_prod[LEVEL_BITS+17:16]);
    env_d    = env_sum[LEVEL_BITS-1:0];
  end

  // Hysteresis gate with saturating loud and quiet counters.
  always_comb begin
    loud_c    = s1_clear_q ? '0 : loud_q;
    quiet_c   = s1_clear_q ? '0 : quiet_q;
    loud_inc  = (&loud_c) ? loud_c : loud_c + 1'b1;
    quiet_inc = (&quiet_c) ? quiet_c : quiet_c + 1'b1;
    loud_d    = loud_c;
    quiet_d   = quiet_c;
    armed_d   = armed_q;
    start_d   = 1'b0;
    if (trig_en_i) begin
      if (!armed_q || s1_rec_q) begin
        if (env_d < thr_off_i) begin
          if (quiet_inc >= rearm_i) begin
            armed_d = 1'b1;
            quiet_d = '0;
          end else begin
            quiet_d = quiet_inc;
          end
        end else begin
          quiet_d = '0;
        end
      end else if (env_d >= thr_on_i) begin
        if (loud_inc >= hold_i) begin
          start_d = 1'b1;
          armed_d = 1'b0;
          loud_d  = '0;
        end else begin
          loud_d = loud_inc;
        end
      end else begin
        loud_d = '0;
      end
    end
  end

  // State update on each processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q   <= '0;
      loud_q  <= '0;
      quiet_q <= '0;
      armed_q <= 1'b1;
    end else if (advance) begin
      env_q   <= env_d;
      loud_q  <= loud_d;
      quiet_q <= quiet_d;
      armed_q <= armed_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_start_q <= start_d;
      out_armed_q <= armed_d;
      out_env_q   <= env_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.start_request = out_start_q;
  assign out_if.armed         = out_armed_q;
  assign out_if.envelope      = out_env_q;

  // A start request always leaves the trigger disarmed.
  a_start_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_start_q |-> !out_armed_q)
    else $error("start request reported while armed");

  // Re-arming clears the quiet counter.
  a_rearm_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(armed_q) |-> (quiet_q == '0))
    else $error("armed without clearing quiet count");

  // A start clears the loud counter.
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && start_d |=> (loud_q == '0) && !armed_q)
    else $error("loud count kept after start");

  // No transfer is taken while the thresholds are settling.
  a_settle_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !thr_ready_i |-> !in_if.ready)
    else $error("input ready while thresholds settle");

endmodule

>>> hdl/envelope_auto_start_trigger_core.sv
// ----------------------------------------------------------------------------
// Envelope auto start trigger
// Envelope follower with a hysteresis gate that requests an automatic start.
// ----------------------------------------------------------------------------
// After its transfer, a sample waits in the input register and moves to the result register once that is free.
// Throughput: one sample per cycle unless the output stalls or the thresholds are settling.
// Thresholds are re-derived through the on and off threshold registers after any
// register write; input is held off until both are current, and also after reset.
// Reset (rst_ni, asynchronous, active low): envelope and counters zero, armed,
// registers at their documented defaults.
module envelope_auto_start_trigger_core
  import east_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  east_in_if.sink                       in_if,
  east_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [east_max(east_max(LEVEL_BITS, COUNT_BITS), SENS_BITS)-1:0] cfg_data_i
);

  logic [COEF_BITS-1:0]  attack, release_c;
  logic [LEVEL_BITS-1:0] thr_on, thr_off;
  logic [COUNT_BITS-1:0] hold, rearm;
  logic                  trig_en, thr_ready;

  // Configuration registers and threshold derivation.
  east_cfg_regs #(
    .LEVEL_BITS (LEVEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .attack_o    (attack),
    .release_o   (release_c),
    .thr_on_o    (thr_on),
    .thr_off_o   (thr_off),
    .hold_o      (hold),
    .rearm_o     (rearm),
    .trig_en_o   (trig_en),
    .thr_ready_o (thr_ready)
  );

  // Sample datapath.
  east_core #(
    .LEVEL_BITS (LEVEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .attack_i    (attack),
    .release_i   (release_c),
    .thr_on_i    (thr_on),
    .thr_off_i   (thr_off),
    .hold_i      (hold),
    .rearm_i     (rearm),
    .trig_en_i   (trig_en),
    .thr_ready_i (thr_ready)
  );

endmodule
